### rtl/cppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types and constants of the column post pixel decoder.
// ----------------------------------------------------------------------------
package cppd_pkg;

    localparam int MAX_COLUMN_BYTES = 512;   // 16 .. 1023
    localparam int MAX_COLUMNS      = 4096;  // 1 .. 65536

    localparam int BCNT_W   = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [7:0] ROW_END = 8'd255;
    localparam logic [BCNT_W-1:0] BCNT_MAX = {BCNT_W{1'b1}};

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ORIGIN_X    = 8'd0;
    localparam t_cfg_idx CFG_ORIGIN_Y    = 8'd1;
    localparam t_cfg_idx CFG_CLIP_RIGHT  = 8'd2;
    localparam t_cfg_idx CFG_CLIP_BOTTOM = 8'd3;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [7:0]         color;
        logic               overrun_error;
    } t_result;

endpackage

### rtl/cppd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppd_if
// Handshake channels of the decoder: byte input, pixel output, config write.
// ----------------------------------------------------------------------------
interface cppd_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        column_start;
    logic [11:0] column_index;

    modport source (output valid, data_byte, column_start, column_index, input ready);
    modport sink   (input valid, data_byte, column_start, column_index, output ready);
endinterface

interface cppd_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         color;
    logic               overrun_error;

    modport source (output valid, pixel_x, pixel_y, color, overrun_error, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color, overrun_error, output ready);
endinterface

interface cppd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cppd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppd_parser
// Post phase machine and pixel address/clip logic; one byte per accepted beat.
// ----------------------------------------------------------------------------
module cppd_parser
    import cppd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_column_start,
    input  logic [11:0] i_column_index,
    input  t_cfg        i_cfg,
    output logic        o_res_vld,
    output t_result     o_res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_ROW, PH_LEN, PH_PAD1, PH_PIX, PH_PAD2, PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase, ph;
    logic [7:0]          r_row, n_row;
    logic [7:0]          r_len, n_len;
    logic [7:0]          r_pcnt, n_pcnt;
    logic [BCNT_W-1:0]   r_bcnt, n_bcnt, bcnt;

    logic signed [17:0]  pix_x, pix_y;
    logic                col_ok, in_clip;
    logic                res_vld;
    t_result             res;

    // screen position; both lower clip edges hold by construction
    assign pix_x  = 18'(i_cfg.origin_x) + $signed({6'b0, i_column_index});
    assign pix_y  = 18'(i_cfg.origin_y) + $signed({10'b0, r_row}) + $signed({10'b0, r_pcnt});
    assign col_ok = {5'b0, i_column_index} < 17'(MAX_COLUMNS);
    assign in_clip = (pix_x <= 18'(i_cfg.clip_right)) && (pix_y <= 18'(i_cfg.clip_bottom));

    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_len   = r_len;
        n_pcnt  = r_pcnt;
        n_bcnt  = r_bcnt;
        ph      = r_phase;
        bcnt    = r_bcnt;
        res_vld = 1'b0;
        res     = '0;
        if (i_column_start) begin
            ph      = PH_ROW;
            bcnt    = '0;
            n_phase = PH_ROW;
            n_bcnt  = '0;
        end
        if (ph != PH_IDLE && ph != PH_DONE) begin
            n_bcnt = (bcnt == BCNT_MAX) ? bcnt : bcnt + 1'b1;
            case (ph)
                PH_ROW: begin
                    if (i_data_byte == ROW_END) begin
                        n_phase = PH_DONE;
                    end else if (bcnt >= BCNT_W'(MAX_COLUMN_BYTES - 1)) begin
                        n_phase = PH_DONE;
                        res_vld = 1'b1;
                        res.overrun_error = 1'b1;
                    end else begin
                        n_row   = i_data_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = i_data_byte;
                    n_pcnt  = '0;
                    n_phase = PH_PAD1;
                end
                PH_PAD1: begin
                    n_phase = (r_len != '0) ? PH_PIX : PH_PAD2;
                end
                PH_PIX: begin
                    n_pcnt = r_pcnt + 1'b1;
                    if (n_pcnt == r_len) begin
                        n_phase = PH_PAD2;
                    end
                    if (col_ok && in_clip) begin
                        res_vld       = 1'b1;
                        res.pixel_x   = pix_x[15:0];
                        res.pixel_y   = pix_y[15:0];
                        res.color     = i_data_byte;
                    end
                end
                default: begin
                    n_phase = PH_ROW;
                end
            endcase
        end
    end

    assign o_res_vld = i_accept && res_vld;
    assign o_res     = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_row   <= '0;
            r_len   <= '0;
            r_pcnt  <= '0;
            r_bcnt  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_len   <= n_len;
            r_pcnt  <= n_pcnt;
            r_bcnt  <= n_bcnt;
        end
    end

endmodule

### rtl/column_post_pixel_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_post_pixel_decoder_unit
// Parses run-length column posts one byte per beat and emits clipped pixel
// writes, or one overrun error for a column without terminator in time.
//
//   channel   dir  beat
//   i_byte    in   data_byte, column_start, column_index
//   o_pixel   out  pixel_x, pixel_y, color, overrun_error
//   i_cfg     in   index, data (origin_x, origin_y, clip_right, clip_bottom)
//
// One byte per cycle while i_byte.ready is high; each result is registered.
// Throughput is set by the output register plus one skid entry: i_byte
// drops ready only when both hold results that o_pixel has not taken.
// Synchronous active-low reset clears the parser and both output slots and
// loads the reset window; config writes are taken in any cycle.
// ----------------------------------------------------------------------------
module column_post_pixel_decoder_unit
    import cppd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cppd_byte_if.sink     i_byte,
    cppd_pixel_if.source  o_pixel,
    cppd_cfg_if.sink      i_cfg
);

    t_cfg     r_cfg;
    logic     accept, out_take;
    logic     res_vld;
    t_result  res;
    logic     r_out_vld, r_skid_vld;
    t_result  r_out, r_skid;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !r_skid_vld;
    assign accept       = i_byte.valid && i_byte.ready;
    assign out_take     = r_out_vld && o_pixel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= 16'sd0;
            r_cfg.origin_y    <= 16'sd0;
            r_cfg.clip_right  <= 16'sd319;
            r_cfg.clip_bottom <= 16'sd199;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg.data;
                CFG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg.data;
                CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg.data;
                CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    cppd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_byte.data_byte),
        .i_column_start (i_byte.column_start),
        .i_column_index (i_byte.column_index),
        .i_cfg          (r_cfg),
        .o_res_vld      (res_vld),
        .o_res          (res)
    );

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (res_vld) begin
            if (!r_out_vld || out_take) begin
                r_out     <= res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= res;
                r_skid_vld <= 1'b1;
            end
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_pixel.valid         = r_out_vld;
    assign o_pixel.pixel_x       = r_out.pixel_x;
    assign o_pixel.pixel_y       = r_out.pixel_y;
    assign o_pixel.color         = r_out.color;
    assign o_pixel.overrun_error = r_out.overrun_error;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |=> r_out_vld)
        else $error("new result not held");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && out_take) |=> (r_out_vld && !r_skid_vld))
        else $error("skid entry not moved on output take");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.overrun_error) |->
            (res.pixel_x == 16'sd0 && res.pixel_y == 16'sd0 && res.color == 8'd0))
        else $error("overrun result carries pixel data");

endmodule

### verif/pixel_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_stream_checker
// Watches the byte, pixel and config channels of the column post decoder.
// Keeps its own copy of the window registers and the post parser, predicts
// the pixel or overrun beat caused by each accepted byte, and compares every
// accepted output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_stream_checker
    import cppd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cppd_byte_if  i_byte,
    cppd_pixel_if i_pixel,
    cppd_cfg_if   i_cfg,
    output int    o_mismatches,
    output int    o_outstanding
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_ROW_START,
        SCAN_LENGTH,
        SCAN_PAD_HEAD,
        SCAN_PIXELS,
        SCAN_PAD_TAIL,
        SCAN_DONE
    } t_scan_phase;

    t_scan_phase        scan;
    logic [7:0]         row_base;
    logic [7:0]         run_len;
    logic [7:0]         pix_idx;
    logic [BCNT_W-1:0]  byte_cnt;
    logic signed [15:0] win_ox;
    logic signed [15:0] win_oy;
    logic signed [15:0] win_right;
    logic signed [15:0] win_bottom;
    t_result            pending_pixels[$];

    task note_mismatch(input string msg);
        $display("[%0t] pixel check: %s", $time, msg);
        o_mismatches++;
    endtask

    task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%04h, want 0x%04h", name, got, want));
    endtask

    // one byte through the post parser; emit is set when a beat is due
    task decode_byte(input logic [7:0] d, input logic s, input logic [11:0] c,
                     output bit emit, output t_result res);
        int unsigned pos;
        int px;
        int py;
        emit = 1'b0;
        res  = '0;
        if (s) begin
            scan     = SCAN_ROW_START;
            byte_cnt = '0;
        end
        if (scan == SCAN_IDLE || scan == SCAN_DONE)
            return;
        pos = byte_cnt;
        if (byte_cnt != BCNT_MAX)
            byte_cnt++;
        case (scan)
            SCAN_ROW_START: begin
                if (d == ROW_END) begin
                    scan = SCAN_DONE;
                end else if (pos + 1 >= MAX_COLUMN_BYTES) begin
                    scan = SCAN_DONE;
                    emit = 1'b1;
                    res.overrun_error = 1'b1;
                end else begin
                    row_base = d;
                    scan     = SCAN_LENGTH;
                end
            end
            SCAN_LENGTH: begin
                run_len = d;
                pix_idx = '0;
                scan    = SCAN_PAD_HEAD;
            end
            SCAN_PAD_HEAD: begin
                scan = (run_len != 0) ? SCAN_PIXELS : SCAN_PAD_TAIL;
            end
            SCAN_PIXELS: begin
                // full-width coordinates, window test before truncation
                px = int'(win_ox) + int'(c);
                py = int'(win_oy) + int'(row_base) + int'(pix_idx);
                pix_idx++;
                if (pix_idx == run_len)
                    scan = SCAN_PAD_TAIL;
                if (c < MAX_COLUMNS && px >= int'(win_ox) && py >= int'(win_oy) &&
                    px <= int'(win_right) && py <= int'(win_bottom)) begin
                    emit          = 1'b1;
                    res.pixel_x   = px[15:0];
                    res.pixel_y   = py[15:0];
                    res.color     = d;
                end
            end
            default: begin
                scan = SCAN_ROW_START;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        bit      emit;
        t_result want;
        if (!i_rst_n) begin
            scan       = SCAN_IDLE;
            row_base   = '0;
            run_len    = '0;
            pix_idx    = '0;
            byte_cnt   = '0;
            win_ox     = 16'sd0;
            win_oy     = 16'sd0;
            win_right  = 16'sd319;
            win_bottom = 16'sd199;
            pending_pixels.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ORIGIN_X:    win_ox     = i_cfg.data;
                    CFG_ORIGIN_Y:    win_oy     = i_cfg.data;
                    CFG_CLIP_RIGHT:  win_right  = i_cfg.data;
                    CFG_CLIP_BOTTOM: win_bottom = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_byte.valid && i_byte.ready) begin
                decode_byte(i_byte.data_byte, i_byte.column_start, i_byte.column_index,
                            emit, want);
                if (emit)
                    pending_pixels.push_back(want);
            end
            if (i_pixel.valid && i_pixel.ready) begin
                if (pending_pixels.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat x=%0d y=%0d color=%0d err=%0b",
                                            i_pixel.pixel_x, i_pixel.pixel_y,
                                            i_pixel.color, i_pixel.overrun_error));
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_x", i_pixel.pixel_x, want.pixel_x);
                    check_field("pixel_y", i_pixel.pixel_y, want.pixel_y);
                    check_field("color", {8'h00, i_pixel.color}, {8'h00, want.color});
                    check_field("overrun_error", {15'h0000, i_pixel.overrun_error},
                                {15'h0000, want.overrun_error});
                end
            end
        end
        o_outstanding = pending_pixels.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the column post pixel decoder: a short directed column set,
// then random columns under several clip windows, including two columns
// that run to the byte limit. Bytes go out in bursts with gaps, the pixel
// side stalls on its own pattern, and a separate checker scores the beats.
// ----------------------------------------------------------------------------
module tb;
    import cppd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int COL_MEAN_BYTES = 40;

    logic i_clk;
    logic i_rst_n;

    cppd_byte_if  byte_ch();
    cppd_pixel_if pix_ch();
    cppd_cfg_if   cfg_ch();

    int          mismatches;
    int          outstanding;
    int          cycle_count;
    int          items_sent;
    int          burst_left;
    int          hold_left;
    int          stall_left;
    int          col_hi;
    bit          gaps_on;
    bit          hold_req;
    bit          first_of_col;
    logic [11:0] cur_col;

    column_post_pixel_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pixel (pix_ch),
        .i_cfg   (cfg_ch)
    );

    pixel_stream_checker pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (byte_ch),
        .i_pixel       (pix_ch),
        .i_cfg         (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // pixel side: random short stalls, quiet windows, one long hold on request
    initial begin : pixel_sink
        bit rdy;
        bit hold_taken;
        pix_ch.ready = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        hold_taken   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if ((cycle_count / 512) % 4 != 3 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            pix_ch.ready <= rdy;
        end
    end

    // called and returns at a falling edge
    task put_byte(input logic [7:0] d, input logic s, input logic [11:0] c, input bit counted);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        byte_ch.data_byte    <= d;
        byte_ch.column_start <= s;
        byte_ch.column_index <= c;
        byte_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        if (counted)
            items_sent++;
    endtask

    task col_byte(input logic [7:0] d);
        logic [11:0] c;
        c = ($urandom_range(0, 15) == 0) ? 12'($urandom) : cur_col;
        put_byte(d, first_of_col, c, 1'b1);
        first_of_col = 1'b0;
    endtask

    // a post cut short (npix < len) has no closing pad
    task send_post(input int row, input int len, input int npix);
        col_byte(8'(row));
        col_byte(8'(len));
        col_byte(8'($urandom));
        repeat (npix) col_byte(8'($urandom));
        if (npix == len)
            col_byte(8'($urandom));
    endtask

    function automatic int pick_row();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 20);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 5);
        if (r < 95)
            return $urandom_range(6, 30);
        return $urandom_range(31, 255);
    endfunction

    task send_column();
        int n_posts;
        int len;
        int r;
        cur_col      = 12'($urandom_range(0, col_hi));
        first_of_col = 1'b1;
        n_posts      = $urandom_range(0, 4);
        repeat (n_posts) begin
            len = pick_len();
            send_post(pick_row(), len, len);
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            col_byte(ROW_END);
            repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0, 12'($urandom), 1'b0);
        end else if (r < 90) begin
            // left open: the next column start drops it
            len = $urandom_range(1, 20);
            send_post(pick_row(), len, $urandom_range(0, len - 1));
        end else begin
            repeat ($urandom_range(1, 6)) col_byte(8'($urandom));
        end
    endtask

    // 259 + 252 bytes put the next row start at position 511 (limit hit);
    // 259 + 251 put it at 510, so one more post is accepted and run in full
    task send_long_column(input bit reach_limit);
        cur_col      = 12'($urandom_range(0, col_hi));
        first_of_col = 1'b1;
        send_post($urandom_range(0, 254), 255, 255);
        if (reach_limit) begin
            send_post($urandom_range(0, 254), 248, 248);
        end else begin
            send_post($urandom_range(0, 254), 247, 247);
            send_post($urandom_range(0, 254), 3, 3);
        end
        col_byte(8'($urandom_range(0, 254)));
        col_byte(8'($urandom));
    endtask

    // stop early by about one mean column so the last one lands near the quota
    task run_columns(input int quota);
        int target;
        target = items_sent + quota;
        while (items_sent + COL_MEAN_BYTES < target)
            send_column();
    endtask

    task load_window(input logic [15:0] ox, input logic [15:0] oy,
                     input logic [15:0] cr, input logic [15:0] cb);
        logic [15:0] vals [4];
        t_cfg_idx    regs [4];
        int          k;
        vals = '{ox, oy, cr, cb};
        regs = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_CLIP_RIGHT, CFG_CLIP_BOTTOM};
        for (k = 0; k < 4; k++) begin
            cfg_ch.index <= regs[k];
            cfg_ch.data  <= vals[k];
            cfg_ch.valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // wait out every predicted beat, then let bytes with no result drain
    task settle();
        byte_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int ph;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.column_start = 1'b0;
        byte_ch.column_index = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        i_rst_n              = 1'b0;
        items_sent           = 0;
        burst_left           = 0;
        gaps_on              = 1'b1;
        hold_req             = 1'b0;
        first_of_col         = 1'b0;
        cur_col              = '0;
        col_hi               = 400;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window; byte before any column start is ignored
        put_byte(8'h3C, 1'b0, 12'd7, 1'b1);
        put_byte(8'd0, 1'b1, 12'd0, 1'b1);
        put_byte(8'd1, 1'b0, 12'd0, 1'b1);
        put_byte(8'hA5, 1'b0, 12'd0, 1'b1);
        put_byte(8'h00, 1'b0, 12'd0, 1'b1);
        put_byte(8'hFF, 1'b0, 12'd0, 1'b1);
        // zero-length post
        put_byte(8'd5, 1'b0, 12'd0, 1'b1);
        put_byte(8'd0, 1'b0, 12'd0, 1'b1);
        put_byte(8'h5A, 1'b0, 12'd0, 1'b1);
        put_byte(8'hFF, 1'b0, 12'd0, 1'b1);
        // rows past the bottom edge
        put_byte(8'd254, 1'b0, 12'd0, 1'b1);
        put_byte(8'd2, 1'b0, 12'd0, 1'b1);
        put_byte(8'h00, 1'b0, 12'd0, 1'b1);
        put_byte(8'hFF, 1'b0, 12'd0, 1'b1);
        put_byte(8'hAA, 1'b0, 12'd0, 1'b1);
        put_byte(8'h00, 1'b0, 12'd0, 1'b1);
        put_byte(ROW_END, 1'b0, 12'd0, 1'b1);
        put_byte(8'h11, 1'b0, 12'd0, 1'b1);
        // top column index, interrupted mid-post by a new column start
        put_byte(8'd10, 1'b1, 12'd4095, 1'b1);
        put_byte(8'd3, 1'b0, 12'd4095, 1'b1);
        put_byte(8'h00, 1'b0, 12'd4095, 1'b1);
        put_byte(8'h77, 1'b0, 12'd4095, 1'b1);
        // bottom-right corner of the reset window
        put_byte(8'd199, 1'b1, 12'd319, 1'b1);
        put_byte(8'd1, 1'b0, 12'd319, 1'b1);
        put_byte(8'hFF, 1'b0, 12'd319, 1'b1);
        put_byte(8'h55, 1'b0, 12'd319, 1'b1);
        put_byte(8'h00, 1'b0, 12'd319, 1'b1);
        put_byte(ROW_END, 1'b0, 12'd319, 1'b1);

        run_columns(60);

        for (ph = 1; ph <= 7; ph++) begin
            settle();
            case (ph)
                1: begin
                    load_window(16'd0, 16'd0, 16'd4095, 16'd511);
                    col_hi   = 4095;
                    hold_req = 1'b1;
                    send_long_column(1'b1);
                    send_long_column(1'b0);
                    run_columns(50);
                end
                2: begin
                    load_window(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
                    gaps_on = 1'b0;
                    run_columns(80);
                end
                3: begin
                    // x and y run past 16 bits before the window test
                    load_window(16'd32000, 16'd32500, 16'h7FFF, 16'h7FFF);
                    gaps_on = 1'b1;
                    col_hi  = 1000;
                    run_columns(80);
                end
                4: begin
                    load_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                    col_hi = 4095;
                    run_columns(80);
                end
                5: begin
                    load_window(16'(-100), 16'(-50), 16'd100, 16'd60);
                    col_hi = 250;
                    run_columns(80);
                end
                6: begin
                    load_window(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                    col_hi = 3;
                    run_columns(50);
                end
                default: begin
                    load_window(16'd0, 16'd0, 16'd319, 16'd199);
                    col_hi = 400;
                    run_columns(60);
                end
            endcase
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/cppd_pkg.sv
rtl/cppd_if.sv
rtl/cppd_parser.sv
rtl/column_post_pixel_decoder_unit.sv
verif/pixel_stream_checker.sv
verif/tb.sv
